>>> hw/rtl/unique_value_set_table_defines.svh
// Assertion macros shared by the unique value set table RTL.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef UNIQUE_VALUE_SET_TABLE_DEFINES_SVH
`define UNIQUE_VALUE_SET_TABLE_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define UVST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the condition holds, the consequence must hold on the next clock edge.
`define UVST_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/uvst_pkg.sv
// Package for the unique value set table: sizes, request codes, the
// controller states and the command and status structs. No dependencies.
package uvst_pkg;

  localparam int SLOTS   = 16;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int VALUE_W = 32;
  localparam int REQ_W   = 2;
  localparam int ENTRY_W = 5;
  localparam int OUT_W   = 8;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

>>> hw/rtl/unique_value_set_table.sv
// Top level of the unique value set table: a set of up to SLOTS distinct values.
// Depends on uvst_pkg, uvst_ctrl and uvst_datapath.
//
// Requests enter on the slave stream: s_tuser carries the request kind
// (insert, remove or lookup; code 3 acts as a lookup) and s_tdata the value.
// Each request gives exactly one response on the master stream, in order.
// The response tells whether the value was present, whether the set changed,
// whether an insert was refused because every slot is used, and the count.
// A request is taken in the idle state, compared against all slots in parallel
// in the compare state and committed in the commit state, where the response
// is registered; a new request is taken only once the controller is idle again.
// The three-state controller sets this order. The response sits in an output
// register, so the next request is accepted while it waits; if the receiver
// still stalls when the following commit is due, the commit waits and
// s_tready stays low until the register is free.
// Reset clears every valid bit and the count at once; the set is empty and
// ready as soon as reset is released.
module unique_value_set_table import uvst_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,  // value[31:0]
  input  logic [1:0]       s_tuser,  // req_type[1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata   // was_present[0], changed[1], table_full[2],
                                     // entry_count[7:3]
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  uvst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  uvst_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_type  (s_tuser),
    .value     (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

>>> hw/rtl/uvst_ctrl.sv
// Controller state machine of the unique value set table.
// Depends on uvst_pkg; drives the datapath through ctrl_cmd_t.
module uvst_ctrl import uvst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/uvst_datapath.sv
// Datapath of the unique value set table: slot registers, parallel match,
// free slot search, count and the result register. Depends on uvst_pkg.
`include "unique_value_set_table_defines.svh"

module uvst_datapath import uvst_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_cmd_t                 cmd,
  output dp_status_t                status,
  input  logic [REQ_W-1:0]          req_type,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [OUT_W-1:0]          out_data
);

  logic [VALUE_W-1:0] slot_values [SLOTS];
  logic [SLOTS-1:0]   slot_valid;
  logic [CNT_W-1:0]   held_count;

  logic [REQ_W-1:0]   req_r;
  logic [VALUE_W-1:0] value_r;
  logic [SLOTS-1:0]   match;
  logic [SLOTS-1:0]   free_oh;
  logic [SLOTS-1:0]   match_r;
  logic [SLOTS-1:0]   free_r;
  logic               present_r;
  logic               has_free_r;

  logic               insert_ok;
  logic               remove_ok;
  logic               refused;
  logic [SLOTS-1:0]   slot_valid_next;
  logic [CNT_W-1:0]   held_count_next;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = slot_valid[i] && (slot_values[i] == value_r);
    end
    free_oh = ~slot_valid & (slot_valid + SLOTS'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= req_type;
      value_r <= value;
    end
    if (cmd.compare) begin
      match_r    <= match;
      free_r     <= free_oh;
      present_r  <= |match;
      has_free_r <= ~&slot_valid;
    end
  end

  assign insert_ok = (req_r == REQ_INSERT) && !present_r && has_free_r;
  assign refused   = (req_r == REQ_INSERT) && !present_r && !has_free_r;
  assign remove_ok = (req_r == REQ_REMOVE) && present_r;

  always_comb begin
    slot_valid_next = slot_valid;
    held_count_next = held_count;
    if (insert_ok) begin
      slot_valid_next = slot_valid | free_r;
      held_count_next = held_count + CNT_W'(1);
    end else if (remove_ok) begin
      slot_valid_next = slot_valid & ~match_r;
      if (held_count != '0) begin
        held_count_next = held_count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.commit) begin
        slot_valid <= slot_valid_next;
        held_count <= held_count_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (cmd.commit && insert_ok && free_r[i]) begin
        slot_values[i] <= value_r;
      end
    end
    if (cmd.commit) begin
      out_data <= {ENTRY_W'(held_count_next), refused, insert_ok || remove_ok, present_r};
    end
  end

  assign status.out_busy = out_valid && !out_ready;

  `UVST_ASSERT(a_count_matches_valid, $countones(slot_valid) == held_count, "count disagrees with valid bits")
  `UVST_ASSERT(a_single_match, $onehot0(match), "value held in more than one slot")
  `UVST_ASSERT_NEXT(a_insert_counts, cmd.commit && insert_ok, held_count == $past(held_count) + CNT_W'(1), "insert did not raise the count")
  `UVST_ASSERT_NEXT(a_remove_clears, cmd.commit && remove_ok, (slot_valid & $past(match_r)) == '0, "remove left the slot valid")

endmodule
